// File: rtl/core/etbt_pkg.sv
// ----------------------------------------------------------------------------
// etbt_pkg
// Types, constants and calendar helpers for the elapsed time unit.
// ----------------------------------------------------------------------------
package etbt_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int ELAPSED_W = 40;

	// floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV100_PW    = YEAR_W + 13;
	localparam int CENT_W       = 8;

	localparam int YEARDAY_W = 23;
	localparam int MOFF_W    = 9;
	localparam int DAYNUM_W  = 24;
	localparam int DAYS_W    = DAYNUM_W + 1;
	localparam int HM_W      = 12;
	localparam int SDIFF_W   = SECOND_W + 1;
	localparam int MINS_W    = 36;
	localparam int SECS_W    = MINS_W + 6;

	localparam int DAYS_PER_YEAR = 365;
	localparam int MIN_PER_DAY   = 1440;
	localparam int SEC_PER_MIN   = 60;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef struct packed {
		logic [YEAR_W-1:0]   start_year;
		logic [MONTH_W-1:0]  start_month;
		logic [DAY_W-1:0]    start_day;
		logic [HOUR_W-1:0]   start_hour;
		logic [MINUTE_W-1:0] start_minute;
		logic [SECOND_W-1:0] start_second;
		logic [YEAR_W-1:0]   end_year;
		logic [MONTH_W-1:0]  end_month;
		logic [DAY_W-1:0]    end_day;
		logic [HOUR_W-1:0]   end_hour;
		logic [MINUTE_W-1:0] end_minute;
		logic [SECOND_W-1:0] end_second;
	} in_word_t;

	typedef struct packed {
		logic signed [ELAPSED_W-1:0] elapsed;
		logic                        input_error;
	} out_word_t;

	function automatic logic [MOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [MOFF_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
	                                                   input logic leap);
		logic [DAY_W-1:0] r;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			MONTH_FEB:               r = leap ? 5'd29 : 5'd28;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/elapsed_time_between_timestamps_unit.sv
// ----------------------------------------------------------------------------
// elapsed_time_between_timestamps_unit
// Signed elapsed time between two Gregorian timestamps, in seconds or minutes.
// ----------------------------------------------------------------------------
// Five-stage pipeline: one word enters per cycle while in_stall is low.
// Stage 1 splits each year by 100 with a reciprocal multiply, stage 2 forms
// leap flags, date checks and year/month day offsets, stage 3 subtracts the
// day numbers, stage 4 scales days to minutes and stage 5 to seconds. A
// stall holds the full stages from stage 5 back to the first empty one;
// empty stages still fill. cfg_wdata selects minutes (1) or seconds (0); the
// user must write it only while the pipeline is empty, as the block does
// not enforce it. A bad month or day gives input_error = 1 and elapsed = 0.
module elapsed_time_between_timestamps_unit
	import etbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	logic mode_q;

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic [YEAR_W-1:0]   yr_s1 [2];
	logic [MONTH_W-1:0]  mo_s1 [2];
	logic [DAY_W-1:0]    dy_s1 [2];
	logic [CENT_W-1:0]   cen_s1 [2];
	logic [HOUR_W-1:0]   hr_s1 [2];
	logic [MINUTE_W-1:0] mn_s1 [2];
	logic [SECOND_W-1:0] sc_s1 [2];
	logic [YEAR_W-1:0]   yr_in [2];
	logic [DIV100_PW-1:0] prod_c [2];

	// stage 2
	logic [YEARDAY_W-1:0]      yd_s2 [2];
	logic [MOFF_W-1:0]         moff_s2 [2];
	logic [DAY_W-1:0]          dy_s2 [2];
	logic                      err_s2;
	logic signed [HM_W-1:0]    hm_s2;
	logic signed [SDIFF_W-1:0] sd_s2;

	logic [YEAR_W-1:0]    rem_c [2];
	logic                 rnz_c [2];
	logic                 leap_c [2];
	logic [12:0]          c4_c [2];
	logic [CENT_W:0]      c100_c [2];
	logic [CENT_W-2:0]    c400_c [2];
	logic [YEARDAY_W-1:0] yd_c [2];
	logic [MOFF_W-1:0]    moff_c [2];
	logic                 bad_c [2];
	logic signed [HOUR_W:0]   hd_c;
	logic signed [MINUTE_W:0] md_c;
	logic signed [SDIFF_W-1:0] sd_c;
	logic signed [HM_W-1:0]   hm_c;

	// stage 3
	logic signed [DAYS_W-1:0]  days_s3;
	logic signed [HM_W-1:0]    hm_s3;
	logic signed [SDIFF_W-1:0] sd_s3;
	logic                      err_s3;
	logic [DAYNUM_W-1:0]       dn_c [2];

	// stage 4
	logic signed [MINS_W-1:0]  min_s4;
	logic signed [SDIFF_W-1:0] sd_s4;
	logic                      err_s4;

	// stage 5
	out_word_t                 out_s5;
	logic signed [SECS_W-1:0]  sec_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: century quotient by reciprocal multiply
	always_comb begin
		yr_in[0] = in_data.start_year;
		yr_in[1] = in_data.end_year;
		for (int i = 0; i < 2; i++) begin
			prod_c[i] = DIV100_PW'(yr_in[i]) * DIV100_PW'(DIV100_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < 2; i++) begin
				yr_s1[i]  <= yr_in[i];
				cen_s1[i] <= prod_c[i][DIV100_SHIFT +: CENT_W];
			end
			mo_s1[0] <= in_data.start_month;
			dy_s1[0] <= in_data.start_day;
			hr_s1[0] <= in_data.start_hour;
			mn_s1[0] <= in_data.start_minute;
			sc_s1[0] <= in_data.start_second;
			mo_s1[1] <= in_data.end_month;
			dy_s1[1] <= in_data.end_day;
			hr_s1[1] <= in_data.end_hour;
			mn_s1[1] <= in_data.end_minute;
			sc_s1[1] <= in_data.end_second;
		end
	end

	// stage 2: leap rule, date check, days before the year and the month
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem_c[i]  = yr_s1[i] - YEAR_W'(YEAR_W'(cen_s1[i]) * YEAR_W'(100));
			rnz_c[i]  = (rem_c[i] != '0);
			leap_c[i] = ((yr_s1[i][1:0] == 2'b00) && rnz_c[i]) ||
			            (!rnz_c[i] && (cen_s1[i][1:0] == 2'b00));
			c4_c[i]   = 13'(yr_s1[i][YEAR_W-1:2]) + 13'(yr_s1[i][1:0] != 2'b00);
			c100_c[i] = (CENT_W+1)'(cen_s1[i]) + (CENT_W+1)'(rnz_c[i]);
			c400_c[i] = (CENT_W-1)'(cen_s1[i][CENT_W-1:2]) +
			            (CENT_W-1)'(rnz_c[i] || (cen_s1[i][1:0] != 2'b00));
			yd_c[i]   = YEARDAY_W'(yr_s1[i]) * YEARDAY_W'(DAYS_PER_YEAR) +
			            YEARDAY_W'(c4_c[i]) - YEARDAY_W'(c100_c[i]) + YEARDAY_W'(c400_c[i]);
			moff_c[i] = days_before_month(mo_s1[i]) +
			            MOFF_W'((mo_s1[i] > MONTH_FEB) && leap_c[i]);
			bad_c[i]  = !(mo_s1[i] inside {[4'd1:4'd12]}) || (dy_s1[i] == '0) ||
			            (dy_s1[i] > month_length(mo_s1[i], leap_c[i]));
		end
		hd_c = $signed({1'b0, hr_s1[1]}) - $signed({1'b0, hr_s1[0]});
		md_c = $signed({1'b0, mn_s1[1]}) - $signed({1'b0, mn_s1[0]});
		sd_c = $signed({1'b0, sc_s1[1]}) - $signed({1'b0, sc_s1[0]});
		hm_c = HM_W'(hd_c) * HM_W'(SEC_PER_MIN) + HM_W'(md_c);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int i = 0; i < 2; i++) begin
				yd_s2[i]   <= yd_c[i];
				moff_s2[i] <= moff_c[i];
				dy_s2[i]   <= dy_s1[i];
			end
			err_s2 <= bad_c[0] || bad_c[1];
			hm_s2  <= hm_c;
			sd_s2  <= sd_c;
		end
	end

	// stage 3: day number difference
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			dn_c[i] = DAYNUM_W'(yd_s2[i]) + DAYNUM_W'(moff_s2[i]) + DAYNUM_W'(dy_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			days_s3 <= $signed({1'b0, dn_c[1]}) - $signed({1'b0, dn_c[0]});
			hm_s3   <= hm_s2;
			sd_s3   <= sd_s2;
			err_s3  <= err_s2;
		end
	end

	// stage 4: minutes
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			min_s4 <= MINS_W'(days_s3) * MINS_W'(MIN_PER_DAY) + MINS_W'(hm_s3);
			sd_s4  <= sd_s3;
			err_s4 <= err_s3;
		end
	end

	// stage 5: seconds, unit select, error zeroing
	assign sec_c = SECS_W'(min_s4) * SECS_W'(SEC_PER_MIN) + SECS_W'(sd_s4);

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			out_s5.input_error <= err_s4;
			if (err_s4) begin
				out_s5.elapsed <= '0;
			end else if (mode_q) begin
				out_s5.elapsed <= ELAPSED_W'(min_s4);
			end else begin
				out_s5.elapsed <= ELAPSED_W'(sec_c);
			end
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.input_error |-> out_data.elapsed == '0)
		else $error("error word carries nonzero elapsed");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word did not reach stage 1");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && rdy5 |=> v_s5)
		else $error("stage 4 word lost on advance");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall |-> in_stall)
		else $error("full pipeline accepted a word under stall");

endmodule
